// ===== rtl/dgci_pkg.sv =====
// Shared types and constants of the density grid cell inflation block.
package dgci_pkg;

	localparam int OP_W       = 2;
	localparam int USAGE_W    = 40;
	localparam int GAIN_W     = 16;
	localparam int FACTOR_W   = 16;
	localparam int AREA_W     = 24;
	localparam int SIZE_W     = 20;
	localparam int NBIN_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int PROD_W     = USAGE_W + GAIN_W;
	localparam int CNT_W      = 6;

	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 16'd256;

	localparam logic [GAIN_W-1:0]   GAIN_RST  = 16'd256;
	localparam logic [USAGE_W-1:0]  FBA_RST   = 40'd0;
	localparam logic [FACTOR_W-1:0] MAXF_RST  = 16'd512;
	localparam logic [SIZE_W-1:0]   SIZE_RST  = 20'd1;
	localparam logic [NBIN_W-1:0]   NBIN_RST  = 7'd1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ACCUM = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN       = 3'd0,
		CFG_FULL_AREA  = 3'd1,
		CFG_MAX_FACTOR = 3'd2,
		CFG_BIN_WIDTH  = 3'd3,
		CFG_BIN_HEIGHT = 3'd4,
		CFG_BINS_X     = 3'd5,
		CFG_BINS_Y     = 3'd6
	} cfg_index_t;

endpackage

// ===== rtl/dgci_if.sv =====
// Valid/ready channel interfaces for cell requests and factor responses.
interface dgci_req_if #(
	parameter int COORD_BITS = 21
);
	logic                                valid;
	logic                                ready;
	logic [dgci_pkg::OP_W-1:0]           opcode;
	logic signed [COORD_BITS-1:0]        x_offset;
	logic signed [COORD_BITS-1:0]        y_offset;
	logic [dgci_pkg::AREA_W-1:0]         cell_area;
	logic                                is_fixed;

	modport source(output valid, opcode, x_offset, y_offset, cell_area, is_fixed, input ready);
	modport sink(input valid, opcode, x_offset, y_offset, cell_area, is_fixed, output ready);
endinterface

interface dgci_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [dgci_pkg::FACTOR_W-1:0]   factor;

	modport source(output valid, factor, input ready);
	modport sink(input valid, factor, output ready);
endinterface

// ===== rtl/density_grid_cell_inflation_core.sv =====
// One item at a time. Accumulate holds intake while it bins, reads and updates its bin.
// An over-full query also multiplies and divides before its factor is registered; other
// queries skip both, fixed or zero-area queries go straight to the response. A stalled
// response holds only the next query. Binning uses serial dividers, the factor a serial
// shift-and-add multiply and a restoring divider; clear holds intake for a full bin sweep.
// Reset (arst_n low, asynchronous) loads register defaults, then the same zeroing sweep.
module density_grid_cell_inflation_core #(
	parameter int GRID_SIDE  = 64,
	parameter int COORD_BITS = 21
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dgci_req_if.sink                             req,
	dgci_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [dgci_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dgci_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int NBINS  = GRID_SIDE * GRID_SIDE;
	localparam int AW     = (NBINS > 1) ? $clog2(NBINS) : 1;
	localparam int XB     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int NW     = $clog2(GRID_SIDE + 1);
	localparam int PW     = COORD_BITS - 1;
	localparam int SW     = dgci_pkg::SIZE_W;
	localparam int UW     = dgci_pkg::USAGE_W;
	localparam int GW     = dgci_pkg::GAIN_W;
	localparam int FW     = dgci_pkg::FACTOR_W;
	localparam int PRW    = dgci_pkg::PROD_W;
	localparam int CW     = dgci_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_BIN,
		ST_ADDR,
		ST_READ,
		ST_UPD,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	// Configuration registers
	logic [GW-1:0]                   gain_q;
	logic [UW-1:0]                   fba_q;
	logic [FW-1:0]                   maxf_q;
	logic [SW-1:0]                   bw_q;
	logic [SW-1:0]                   bh_q;
	logic [dgci_pkg::NBIN_W-1:0]     nbx_q;
	logic [dgci_pkg::NBIN_W-1:0]     nby_q;

	// Control
	state_t                          state_q;
	logic [CW-1:0]                   cnt_q;
	logic [AW-1:0]                   sweep_q;
	logic                            rsp_valid_q;
	logic [FW-1:0]                   rsp_factor_q;

	// Datapath
	dgci_pkg::opcode_t               op_q;
	logic [dgci_pkg::AREA_W-1:0]     area_q;
	logic [PW-1:0]                   xdiv_q;
	logic [PW-1:0]                   ydiv_q;
	logic [SW-1:0]                   xrem_q;
	logic [SW-1:0]                   yrem_q;
	logic [AW-1:0]                   addr_q;
	logic [UW-1:0]                   rd_q;
	logic [UW-1:0]                   diff_q;
	logic [GW-1:0]                   gsh_q;
	logic [PRW-1:0]                  acc_q;
	logic [UW-1:0]                   rem_q;
	logic [FW-1:0]                   res_q;

	// Bin usage store
	logic [UW-1:0]                   mem [NBINS];
	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [UW-1:0]                   mem_wdata;

	logic                            req_xfer;
	logic                            rsp_load;
	logic                            quick_one;
	logic                            x_neg;
	logic                            y_neg;
	logic [SW-1:0]                   bw_eff;
	logic [SW-1:0]                   bh_eff;
	logic [SW:0]                     x_trial;
	logic [SW:0]                     y_trial;
	logic                            x_ge;
	logic                            y_ge;
	logic [SW-1:0]                   x_rem_nxt;
	logic [SW-1:0]                   y_rem_nxt;
	logic [NW-1:0]                   nx;
	logic [NW-1:0]                   ny;
	logic [XB-1:0]                   bx;
	logic [XB-1:0]                   by;
	logic [AW-1:0]                   addr_nxt;
	logic [UW:0]                     acc_sum;
	logic [UW:0]                     d_trial;
	logic                            d_ge;
	logic [UW-1:0]                   d_rem_nxt;
	logic                            q_ovf;
	logic [FW:0]                     f_sum;
	logic [FW-1:0]                   f_clamp;
	logic [FW-1:0]                   f_final;

	assign req_xfer  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.factor = rsp_factor_q;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Fixed cells and a zero full-bin area answer 1.0 without touching the grid
	assign quick_one = req.is_fixed || (fba_q == '0);
	assign x_neg     = req.x_offset[COORD_BITS-1];
	assign y_neg     = req.y_offset[COORD_BITS-1];

	// Bin size of zero counts as one
	assign bw_eff = (bw_q == '0) ? SW'(1) : bw_q;
	assign bh_eff = (bh_q == '0) ? SW'(1) : bh_q;

	// One restoring-division step per cycle on each axis; the quotient bit
	// shifts into the dividend register as the dividend shifts out.
	assign x_trial   = {xrem_q, xdiv_q[PW-1]};
	assign y_trial   = {yrem_q, ydiv_q[PW-1]};
	assign x_ge      = (x_trial >= {1'b0, bw_eff});
	assign y_ge      = (y_trial >= {1'b0, bh_eff});
	assign x_rem_nxt = x_ge ? SW'(x_trial - {1'b0, bw_eff}) : x_trial[SW-1:0];
	assign y_rem_nxt = y_ge ? SW'(y_trial - {1'b0, bh_eff}) : y_trial[SW-1:0];

	// Grid size in use: zero counts as one, above GRID_SIDE counts as GRID_SIDE
	always_comb begin
		if (nbx_q == '0) begin
			nx = NW'(1);
		end else if (32'(nbx_q) > GRID_SIDE) begin
			nx = NW'(GRID_SIDE);
		end else begin
			nx = NW'(nbx_q);
		end
		if (nby_q == '0) begin
			ny = NW'(1);
		end else if (32'(nby_q) > GRID_SIDE) begin
			ny = NW'(GRID_SIDE);
		end else begin
			ny = NW'(nby_q);
		end
	end

	// Clamp the quotients into the grid and form the row-major bin number
	always_comb begin
		if (32'(xdiv_q) >= 32'(nx)) begin
			bx = XB'(nx - NW'(1));
		end else begin
			bx = XB'(xdiv_q);
		end
		if (32'(ydiv_q) >= 32'(ny)) begin
			by = XB'(ny - NW'(1));
		end else begin
			by = XB'(ydiv_q);
		end
		addr_nxt = AW'(by) * AW'(nx) + AW'(bx);
	end

	// Saturating usage update
	assign acc_sum = {1'b0, rd_q} + (UW + 1)'(area_q);

	// Density ratio divider step: remainder stays below full_bin_area
	assign d_trial   = {rem_q, acc_q[PRW-1]};
	assign d_ge      = (d_trial >= {1'b0, fba_q});
	assign d_rem_nxt = d_ge ? UW'(d_trial - {1'b0, fba_q}) : d_trial[UW-1:0];

	// Factor: 1.0 plus quotient, clamped to max_factor, then raised to 1.0
	assign q_ovf   = |acc_q[PRW-1:FW];
	assign f_sum   = (FW + 1)'(dgci_pkg::FACTOR_ONE) + (FW + 1)'(acc_q[FW-1:0]);
	assign f_clamp = (q_ovf || (f_sum > {1'b0, maxf_q})) ? maxf_q : f_sum[FW-1:0];
	assign f_final = (f_clamp < dgci_pkg::FACTOR_ONE) ? dgci_pkg::FACTOR_ONE : f_clamp;

	// Memory write port: zero during a sweep, saturated sum on accumulate
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
		end else if ((state_q == ST_UPD) && (op_q == dgci_pkg::OP_ACCUM)) begin
			mem_we    = 1'b1;
			mem_wdata = acc_sum[UW] ? {UW{1'b1}} : acc_sum[UW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[addr_q];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= dgci_pkg::GAIN_RST;
			fba_q  <= dgci_pkg::FBA_RST;
			maxf_q <= dgci_pkg::MAXF_RST;
			bw_q   <= dgci_pkg::SIZE_RST;
			bh_q   <= dgci_pkg::SIZE_RST;
			nbx_q  <= dgci_pkg::NBIN_RST;
			nby_q  <= dgci_pkg::NBIN_RST;
		end else if (cfg_we) begin
			case (dgci_pkg::cfg_index_t'(cfg_index))
				dgci_pkg::CFG_GAIN:       gain_q <= cfg_wdata[GW-1:0];
				dgci_pkg::CFG_FULL_AREA:  fba_q  <= cfg_wdata[UW-1:0];
				dgci_pkg::CFG_MAX_FACTOR: maxf_q <= cfg_wdata[FW-1:0];
				dgci_pkg::CFG_BIN_WIDTH:  bw_q   <= cfg_wdata[SW-1:0];
				dgci_pkg::CFG_BIN_HEIGHT: bh_q   <= cfg_wdata[SW-1:0];
				dgci_pkg::CFG_BINS_X:     nbx_q  <= cfg_wdata[dgci_pkg::NBIN_W-1:0];
				dgci_pkg::CFG_BINS_Y:     nby_q  <= cfg_wdata[dgci_pkg::NBIN_W-1:0];
				default: ;
			endcase
		end
	end

	// State, step counter, sweep pointer and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			cnt_q        <= '0;
			sweep_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_factor_q <= dgci_pkg::FACTOR_ONE;
		end else begin
			if (rsp_load) begin
				rsp_valid_q  <= 1'b1;
				rsp_factor_q <= res_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(NBINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_xfer) begin
						case (dgci_pkg::opcode_t'(req.opcode))
							dgci_pkg::OP_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end
							dgci_pkg::OP_ACCUM: begin
								if (!req.is_fixed) begin
									state_q <= ST_BIN;
								end
							end
							dgci_pkg::OP_QUERY: begin
								state_q <= quick_one ? ST_DONE : ST_BIN;
							end
							default: ;
						endcase
					end
				end
				ST_BIN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_UPD;
				ST_UPD: begin
					cnt_q <= '0;
					if (op_q == dgci_pkg::OP_ACCUM) begin
						state_q <= ST_IDLE;
					end else if (rd_q > fba_q) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					if (cnt_q == CW'(GW - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(PRW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					op_q   <= dgci_pkg::opcode_t'(req.opcode);
					area_q <= req.cell_area;
					// Negative offsets land in bin zero: divide zero instead
					xdiv_q <= x_neg ? '0 : req.x_offset[PW-1:0];
					ydiv_q <= y_neg ? '0 : req.y_offset[PW-1:0];
					xrem_q <= '0;
					yrem_q <= '0;
					res_q  <= dgci_pkg::FACTOR_ONE;
				end
			end
			ST_BIN: begin
				xrem_q <= x_rem_nxt;
				yrem_q <= y_rem_nxt;
				xdiv_q <= {xdiv_q[PW-2:0], x_ge};
				ydiv_q <= {ydiv_q[PW-2:0], y_ge};
			end
			ST_ADDR: addr_q <= addr_nxt;
			ST_UPD: begin
				// Hold 1.0 unless the bin is over full
				diff_q <= rd_q - fba_q;
				acc_q  <= '0;
				gsh_q  <= gain_q;
				rem_q  <= '0;
				res_q  <= dgci_pkg::FACTOR_ONE;
			end
			ST_MUL: begin
				// MSB-first shift-and-add of gain times excess usage
				acc_q <= {acc_q[PRW-2:0], 1'b0} + (gsh_q[GW-1] ? PRW'(diff_q) : '0);
				gsh_q <= {gsh_q[GW-2:0], 1'b0};
			end
			ST_DIV: begin
				rem_q <= d_rem_nxt;
				acc_q <= {acc_q[PRW-2:0], d_ge};
			end
			ST_FIN: res_q <= f_final;
			default: ;
		endcase
	end

	// A response never carries a factor below 1.0
	a_factor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.factor >= dgci_pkg::FACTOR_ONE))
		else $error("response factor below 1.0");

	// The ratio divider stops after one pass over the product bits
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CW'(PRW)))
		else $error("divider step count overran");

	// Fixed cells and zero full-bin area answer 1.0 at once
	a_quick_query: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && (req.opcode == dgci_pkg::OP_QUERY) && quick_one)
		|=> ((state_q == ST_DONE) && (res_q == dgci_pkg::FACTOR_ONE)))
		else $error("short query did not answer 1.0");

endmodule

// ===== verif/tb_density_grid_cell_inflation_core.sv =====
// Self-checking testbench for density_grid_cell_inflation_core under flow control.
module tb_density_grid_cell_inflation_core;

	localparam int GRID_SIDE       = 64;
	localparam int COORD_BITS      = 21;
	localparam int NUM_BINS        = GRID_SIDE * GRID_SIDE;
	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 12;
	// A clear sweeps every bin and returns nothing, so allow a full sweep plus margin
	// before touching the registers.
	localparam int SETTLE_CYCLES   = NUM_BINS + 128;
	// Longest query is well within this tail; give spurious results room to show up.
	localparam int TAIL_CYCLES     = 200;
	localparam int TIMEOUT_CYCLES  = 2000000;
	localparam int MAX_REPORTS     = 10;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int OFFSET_MAX      = (1 << (COORD_BITS - 1)) - 1;
	localparam longint unsigned USAGE_SAT = (64'd1 << dgci_pkg::USAGE_W) - 1;

	typedef struct {
		dgci_pkg::opcode_t               op;
		logic signed [COORD_BITS-1:0]    x;
		logic signed [COORD_BITS-1:0]    y;
		logic [dgci_pkg::AREA_W-1:0]     area;
		logic                            fixed;
	} cell_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [dgci_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dgci_pkg::CFG_DATA_W-1:0] cfg_wdata;

	dgci_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
	dgci_rsp_if                            rsp_ch ();

	density_grid_cell_inflation_core #(
		.GRID_SIDE (GRID_SIDE),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Mirror of the register file, updated as each write is driven.
	logic [dgci_pkg::GAIN_W-1:0]   gain_q;
	logic [dgci_pkg::USAGE_W-1:0]  full_area_q;
	logic [dgci_pkg::FACTOR_W-1:0] max_factor_q;
	logic [dgci_pkg::SIZE_W-1:0]   bin_w_q;
	logic [dgci_pkg::SIZE_W-1:0]   bin_h_q;
	logic [dgci_pkg::NBIN_W-1:0]   cols_q;
	logic [dgci_pkg::NBIN_W-1:0]   rows_q;

	// Predicted area per bin; a clear zeroes it, so no separate "touched" flag is kept.
	logic [dgci_pkg::USAGE_W-1:0]  bin_fill [NUM_BINS];
	// Factors owed by queries already accepted, oldest first.
	logic [dgci_pkg::FACTOR_W-1:0] expected_factors [$];

	int          send_idle_pct;
	int          stall_pct;
	int          fail_count;
	int unsigned area_scale;
	int unsigned span_x;
	int unsigned span_y;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("density_grid_cell_inflation_core verification failed");
		$finish;
	end

	// Response side: drop ready at random, re-decided every falling edge.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------------------

	// Grid dimension in use: zero counts as one, anything past the grid as the grid side.
	function automatic int unsigned grid_extent(logic [dgci_pkg::NBIN_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > GRID_SIDE)
			return GRID_SIDE;
		return 32'(n);
	endfunction

	// Bin along one axis: negative offsets land in bin 0, far offsets in the last bin.
	function automatic int unsigned axis_bin(logic signed [COORD_BITS-1:0] pos,
			logic [dgci_pkg::SIZE_W-1:0] size, int unsigned count);
		longint unsigned p;
		longint unsigned s;
		longint unsigned q;
		if (pos < 0)
			return 0;
		p = pos;
		s = (size == 0) ? 1 : size;
		q = p / s;
		if (q >= count)
			q = count - 1;
		return 32'(q);
	endfunction

	function automatic int unsigned cell_bin(cell_t c);
		int unsigned nx;
		int unsigned bx;
		int unsigned by;
		nx = grid_extent(cols_q);
		bx = axis_bin(c.x, bin_w_q, nx);
		by = axis_bin(c.y, bin_h_q, grid_extent(rows_q));
		return (by * nx + bx) % NUM_BINS;
	endfunction

	// factor = 1 + gain * (usage - full) / full, truncated, clamped to max then to >= 1.0
	function automatic logic [dgci_pkg::FACTOR_W-1:0] inflation_for(cell_t c);
		longint unsigned f;
		longint unsigned usage;
		longint unsigned full;
		longint unsigned g;
		f = dgci_pkg::FACTOR_ONE;
		if (!c.fixed && full_area_q != 0) begin
			usage = bin_fill[cell_bin(c)];
			full  = full_area_q;
			g     = gain_q;
			if (usage > full)
				f = dgci_pkg::FACTOR_ONE + (g * (usage - full)) / full;
			if (f > max_factor_q)
				f = max_factor_q;
			if (f < dgci_pkg::FACTOR_ONE)
				f = dgci_pkg::FACTOR_ONE;
		end
		return f[dgci_pkg::FACTOR_W-1:0];
	endfunction

	function automatic cell_t make_cell(dgci_pkg::opcode_t op, int x, int y,
			int unsigned area, bit fixed);
		cell_t c;
		c.op    = op;
		c.x     = x[COORD_BITS-1:0];
		c.y     = y[COORD_BITS-1:0];
		c.area  = area[dgci_pkg::AREA_W-1:0];
		c.fixed = fixed;
		return c;
	endfunction

	// Offset mostly inside the grid, a little past both ends, now and then anywhere.
	function automatic logic signed [COORD_BITS-1:0] pick_offset(int unsigned span);
		int unsigned hi;
		int          v;
		if ($urandom_range(9) == 0)
			return COORD_BITS'($urandom);
		hi = span + span / 8;
		if (hi > OFFSET_MAX)
			hi = OFFSET_MAX;
		v = int'($urandom_range(0, hi)) - int'($urandom_range(0, span / 16));
		return v[COORD_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------------------

	// Present one cell, hold it until the transfer, then advance the bin model.
	// Valid is left high on exit so back-to-back cells need no second assignment.
	task automatic send_cell(cell_t c);
		int unsigned b;
		longint unsigned sum;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= c.op;
		req_ch.x_offset  <= c.x;
		req_ch.y_offset  <= c.y;
		req_ch.cell_area <= c.area;
		req_ch.is_fixed  <= c.fixed;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		case (c.op)
			dgci_pkg::OP_CLEAR: begin
				foreach (bin_fill[i])
					bin_fill[i] = '0;
			end
			dgci_pkg::OP_ACCUM: begin
				if (!c.fixed) begin
					b   = cell_bin(c);
					sum = longint'(bin_fill[b]) + c.area;
					if (sum > USAGE_SAT)
						sum = USAGE_SAT;
					bin_fill[b] = sum[dgci_pkg::USAGE_W-1:0];
				end
			end
			dgci_pkg::OP_QUERY: expected_factors = {expected_factors, inflation_for(c)};
			default: ;
		endcase
	endtask

	// Drop valid, wait out every owed factor, then give a possible clear time to finish.
	task automatic settle;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_factors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(dgci_pkg::cfg_index_t idx, longint unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= dgci_pkg::CFG_DATA_W'(value);
		case (idx)
			dgci_pkg::CFG_GAIN:       gain_q       = value[dgci_pkg::GAIN_W-1:0];
			dgci_pkg::CFG_FULL_AREA:  full_area_q  = value[dgci_pkg::USAGE_W-1:0];
			dgci_pkg::CFG_MAX_FACTOR: max_factor_q = value[dgci_pkg::FACTOR_W-1:0];
			dgci_pkg::CFG_BIN_WIDTH:  bin_w_q      = value[dgci_pkg::SIZE_W-1:0];
			dgci_pkg::CFG_BIN_HEIGHT: bin_h_q      = value[dgci_pkg::SIZE_W-1:0];
			dgci_pkg::CFG_BINS_X:     cols_q       = value[dgci_pkg::NBIN_W-1:0];
			dgci_pkg::CFG_BINS_Y:     rows_q       = value[dgci_pkg::NBIN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reprogram the whole register file with the block idle.
	task automatic configure(longint unsigned gain, longint unsigned full_area,
			longint unsigned max_factor, longint unsigned bin_w, longint unsigned bin_h,
			longint unsigned cols, longint unsigned rows);
		settle();
		write_reg(dgci_pkg::CFG_GAIN,       gain);
		write_reg(dgci_pkg::CFG_FULL_AREA,  full_area);
		write_reg(dgci_pkg::CFG_MAX_FACTOR, max_factor);
		write_reg(dgci_pkg::CFG_BIN_WIDTH,  bin_w);
		write_reg(dgci_pkg::CFG_BIN_HEIGHT, bin_h);
		write_reg(dgci_pkg::CFG_BINS_X,     cols);
		write_reg(dgci_pkg::CFG_BINS_Y,     rows);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------------------------
	// Checker: compare every factor transfer with the oldest prediction.
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin : check_factor
		logic [dgci_pkg::FACTOR_W-1:0] want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_factors.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected factor %0d with no query pending", rsp_ch.factor);
			end else begin
				want = expected_factors.pop_front();
				if (rsp_ch.factor !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("factor mismatch: expected %0d, got %0d", want, rsp_ch.factor);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// Registers at reset: full bin area is zero, so every query must read one.
	task automatic test_reset_registers;
		send_cell(make_cell(dgci_pkg::OP_QUERY, 0, 0, 0, 0));
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 0, 0, 1000, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 5, 5, 0, 0));
	endtask

	// Binning: negative offsets, offsets past the grid, fixed cells, ignored opcode, clear.
	task automatic test_binning;
		configure(256, 1000, 65535, 100, 50, 4, 3);
		send_cell(make_cell(dgci_pkg::OP_ACCUM, -1048576, -1048576, 3000, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 0, 0, 0, 0));
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 1048575, 1048575, 16777215, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 399, 149, 0, 0));
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 50, 20, 5000, 1));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 50, 20, 0, 1));
		send_cell(make_cell(dgci_pkg::OP_NOP, 70, 70, 123456, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 150, 60, 0, 0));
		send_cell(make_cell(dgci_pkg::OP_CLEAR, 0, 0, 0, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 0, 0, 0, 0));
	endtask

	// Register extremes: max below one, zero bin width, grid counts of zero and past
	// the grid, largest sizes and full area, top gain and zero gain.
	task automatic test_factor_limits;
		configure(65535, 1, 100, 0, 1048575, 127, 0);
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 5000, 7, 10, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 63, -3, 0, 0));

		configure(65535, USAGE_SAT, 65535, 1048575, 1, GRID_SIDE, GRID_SIDE);
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 1048575, 63, 16777215, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 1048575, 63, 0, 0));

		configure(65535, 1, 65535, 1, 1, GRID_SIDE, GRID_SIDE);
		send_cell(make_cell(dgci_pkg::OP_ACCUM, 0, 0, 16777215, 0));
		send_cell(make_cell(dgci_pkg::OP_QUERY, 0, 0, 0, 0));

		configure(0, 1, 65535, 1, 1, GRID_SIDE, GRID_SIDE);
		send_cell(make_cell(dgci_pkg::OP_QUERY, 0, 0, 0, 0));
	endtask

	// Random settings, then mostly accumulate/query traffic aimed inside the grid so
	// bins fill past full; a few clears, ignored opcodes and wild offsets mixed in.
	task automatic test_random_traffic(int idle_pct, int stall);
		int unsigned cols;
		int unsigned rows;
		int unsigned bw;
		int unsigned bh;
		int unsigned r;
		int          done;
		cell_t       c;
		cols = ($urandom_range(7) == 0) ? GRID_SIDE : $urandom_range(1, 8);
		rows = ($urandom_range(7) == 0) ? GRID_SIDE : $urandom_range(1, 8);
		bw   = $urandom_range(1, 40000);
		bh   = $urandom_range(1, 40000);
		span_x = (cols * bw > OFFSET_MAX) ? OFFSET_MAX : cols * bw;
		span_y = (rows * bh > OFFSET_MAX) ? OFFSET_MAX : rows * bh;
		area_scale = $urandom_range(1, 1 << 20);
		configure($urandom_range(0, 4096), longint'(area_scale) * $urandom_range(1, 4),
			$urandom_range(256, 65535), bw, bh, cols, rows);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		done = 0;
		while (done < ITEMS_PER_PHASE) begin
			r = $urandom_range(99);
			if (r < 2)
				c.op = dgci_pkg::OP_CLEAR;
			else if (r < 6)
				c.op = dgci_pkg::OP_NOP;
			else if (r < 50)
				c.op = dgci_pkg::OP_ACCUM;
			else
				c.op = dgci_pkg::OP_QUERY;
			c.x     = pick_offset(span_x);
			c.y     = pick_offset(span_y);
			c.area  = ($urandom_range(9) == 0) ? dgci_pkg::AREA_W'($urandom)
			                                   : dgci_pkg::AREA_W'($urandom_range(0, area_scale));
			c.fixed = ($urandom_range(9) == 0);
			send_cell(c);
			if (c.op != dgci_pkg::OP_NOP)
				done++;
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------
	initial begin
		// Drive every input to a known value before reset releases.
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = dgci_pkg::OP_CLEAR;
		req_ch.x_offset  = '0;
		req_ch.y_offset  = '0;
		req_ch.cell_area = '0;
		req_ch.is_fixed  = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = dgci_pkg::CFG_GAIN;
		cfg_wdata        = '0;
		fail_count       = 0;
		send_idle_pct    = 25;
		stall_pct        = 25;
		gain_q           = dgci_pkg::GAIN_RST;
		full_area_q      = dgci_pkg::FBA_RST;
		max_factor_q     = dgci_pkg::MAXF_RST;
		bin_w_q          = dgci_pkg::SIZE_RST;
		bin_h_q          = dgci_pkg::SIZE_RST;
		cols_q           = dgci_pkg::NBIN_RST;
		rows_q           = dgci_pkg::NBIN_RST;
		foreach (bin_fill[i])
			bin_fill[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The zeroing sweep after reset holds off intake; send_cell simply waits on ready.
		test_reset_registers();
		test_binning();
		test_factor_limits();

		test_random_traffic(0, 0);
		test_random_traffic(61, 0);
		test_random_traffic(0, 61);
		test_random_traffic(16, 16);

		// Drain: drop valid, collect every owed factor, then watch for strays.
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_factors.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("density_grid_cell_inflation_core verification clean");
		end else begin
			$display("density_grid_cell_inflation_core verification failed");
		end
		$finish;
	end

endmodule

// ===== density_grid_cell_inflation_core.f =====
rtl/dgci_pkg.sv
rtl/dgci_if.sv
rtl/density_grid_cell_inflation_core.sv
verif/tb_density_grid_cell_inflation_core.sv
